### design/wvbr_pkg.sv
// ----------------------------------------------------------------------------
// wvbr_pkg
// Shared types, constants and the weight clamp for the budget repair block.
// ----------------------------------------------------------------------------
`default_nettype none
package wvbr_pkg;

  localparam int W_W    = 17;  // stored weight width
  localparam int IN_W   = 18;  // raw input weight width
  localparam int SUM_W  = 23;  // clamped / headroom sum width
  localparam int PROD_W = SUM_W + W_W;
  localparam int CASH_W = 18;
  localparam int ST_W   = 2;

  localparam logic [SUM_W-1:0] ONE_Q16 = SUM_W'(65536);

  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_STUCK = 2'd1;
  localparam logic [ST_W-1:0] STATUS_NEG   = 2'd2;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_STUCK,
    MODE_REPAIR
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  hsum;
  } desc_t;

  // max is applied first, then min, so min wins when min > max
  function automatic logic [W_W-1:0] clamp_w(input logic signed [24:0] w,
                                             input logic [W_W-1:0] lo,
                                             input logic [W_W-1:0] hi);
    logic signed [24:0] t;
    t = w;
    if (t > $signed({8'd0, hi})) t = $signed({8'd0, hi});
    if (t < $signed({8'd0, lo})) t = $signed({8'd0, lo});
    return t[W_W-1:0];
  endfunction

endpackage
`default_nettype wire

### design/wvbr_ram.sv
// ----------------------------------------------------------------------------
// wvbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module wvbr_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/wvbr_front.sv
// ----------------------------------------------------------------------------
// wvbr_front
// Config registers, input clamp, entry store writes, sums and vector
// classification; holds one closed-vector descriptor for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module wvbr_front #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [wvbr_pkg::W_W-1:0]      cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic signed [wvbr_pkg::IN_W-1:0] weight_i,
  input  wire logic                          last_i,
  input  wire logic                          desc_ack_i,
  output logic                               desc_valid_o,
  output wvbr_pkg::desc_t                    desc_o,
  output logic [$clog2(MAX_ENTRIES + 1)-1:0] desc_count_o,
  output logic [wvbr_pkg::W_W-1:0]           min_o,
  output logic [wvbr_pkg::W_W-1:0]           max_o,
  output logic                               we_o,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] waddr_o,
  output logic [wvbr_pkg::W_W-1:0]           wdata_o
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [wvbr_pkg::W_W-1:0]   min_q, max_q;
  logic [CW-1:0]              count_q, count_d;
  logic [wvbr_pkg::SUM_W-1:0] sum_q, sum_d, hsum_q, hsum_d;
  logic [wvbr_pkg::W_W-1:0]   wc;
  logic                       close;
  wvbr_pkg::mode_e            mode;

  always_comb begin
    wc      = wvbr_pkg::clamp_w(25'(weight_i), min_q, max_q);
    count_d = count_q + CW'(1);
    sum_d   = sum_q + wvbr_pkg::SUM_W'(wc);
    hsum_d  = hsum_q + wvbr_pkg::SUM_W'(wc - min_q);
    close   = last_i || (count_d == CW'(MAX_ENTRIES));
    if (sum_d <= wvbr_pkg::ONE_Q16) mode = wvbr_pkg::MODE_PASS;
    else if (hsum_d == '0)          mode = wvbr_pkg::MODE_STUCK;
    else                            mode = wvbr_pkg::MODE_REPAIR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= '0;
      max_q        <= wvbr_pkg::W_W'(65536);
      count_q      <= '0;
      sum_q        <= '0;
      hsum_q       <= '0;
      desc_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == wvbr_pkg::CFG_MIN) min_q <= cfg_data_i;
        else                                  max_q <= cfg_data_i;
      end
      if (desc_ack_i) desc_valid_o <= 1'b0;
      if (accept_i) begin
        if (close) begin
          count_q      <= '0;
          sum_q        <= '0;
          hsum_q       <= '0;
          desc_valid_o <= 1'b1;
          desc_o       <= '{mode: mode, sum: sum_d, hsum: hsum_d};
          desc_count_o <= count_d;
        end else begin
          count_q <= count_d;
          sum_q   <= sum_d;
          hsum_q  <= hsum_d;
        end
      end
    end
  end

  assign min_o   = min_q;
  assign max_o   = max_q;
  assign we_o    = accept_i;
  assign waddr_o = count_q[AW-1:0];
  assign wdata_o = wc;
endmodule
`default_nettype wire

### design/wvbr_back.sv
// ----------------------------------------------------------------------------
// wvbr_back
// Walks a closed vector: reads each entry, in repair mode takes its share
// of the excess via a bit-serial divider, clamps again, emits the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module wvbr_back #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          desc_valid_i,
  input  wire wvbr_pkg::desc_t               desc_i,
  input  wire logic [$clog2(MAX_ENTRIES + 1)-1:0] desc_count_i,
  output logic                               desc_ack_o,
  input  wire logic [wvbr_pkg::W_W-1:0]      min_i,
  input  wire logic [wvbr_pkg::W_W-1:0]      max_i,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] raddr_o,
  input  wire logic [wvbr_pkg::W_W-1:0]      rdata_i,
  output logic                               active_o,
  output logic                               valid_o,
  output logic [wvbr_pkg::W_W-1:0]           weight_o,
  output logic signed [wvbr_pkg::CASH_W-1:0] cash_o,
  output logic [wvbr_pkg::ST_W-1:0]          status_o,
  output logic                               last_o
);
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int PW  = wvbr_pkg::PROD_W;
  localparam int SW  = wvbr_pkg::SUM_W;
  localparam int BW  = $clog2(PW);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LOAD, S_DIV, S_EMIT} state_e;

  state_e                  state_q;
  wvbr_pkg::mode_e         mode_q;
  logic [CW-1:0]           idx_q, n_q;
  logic [SW-1:0]           sum_q, hsum_q, excess_q, newsum_q, rem_q;
  logic [wvbr_pkg::W_W-1:0] v_q;
  logic [PW-1:0]           dq_q;
  logic [BW-1:0]           bit_q;

  logic [SW:0]             rem_sh, rem_sub;
  logic                    ge;
  logic [SW-1:0]           red;
  logic [wvbr_pkg::W_W-1:0] vfin;
  logic [SW:0]             total;
  logic signed [25:0]      cash_full;
  logic [wvbr_pkg::CASH_W-1:0] cash_sat;
  logic [wvbr_pkg::ST_W-1:0]   status;
  logic                    fin;

  always_comb begin
    rem_sh  = {rem_q, dq_q[PW-1]};
    rem_sub = rem_sh - {1'b0, hsum_q};
    ge      = rem_sh >= {1'b0, hsum_q};
    red     = (mode_q == wvbr_pkg::MODE_REPAIR) ? dq_q[SW-1:0] : '0;
    vfin    = wvbr_pkg::clamp_w($signed({8'd0, v_q}) - $signed({2'd0, red}), min_i, max_i);
    total   = (mode_q == wvbr_pkg::MODE_REPAIR) ?
              ({1'b0, newsum_q} + (SW + 1)'(vfin)) : {1'b0, sum_q};
    cash_full = $signed(26'd65536) - $signed({2'd0, total});
    cash_sat  = (cash_full < -26'sd131072) ? 18'h20000 : cash_full[17:0];
    if (mode_q == wvbr_pkg::MODE_STUCK)       status = wvbr_pkg::STATUS_STUCK;
    else if (mode_q == wvbr_pkg::MODE_REPAIR && cash_full < 0)
                                              status = wvbr_pkg::STATUS_NEG;
    else                                      status = wvbr_pkg::STATUS_OK;
    fin = (idx_q == n_q - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_o <= (state_q == S_EMIT);
      unique case (state_q)
        S_IDLE: begin
          if (desc_valid_i) begin
            mode_q   <= desc_i.mode;
            sum_q    <= desc_i.sum;
            hsum_q   <= desc_i.hsum;
            excess_q <= desc_i.sum - wvbr_pkg::ONE_Q16;
            n_q      <= desc_count_i;
            idx_q    <= '0;
            newsum_q <= '0;
            state_q  <= S_READ;
          end
        end
        S_READ: state_q <= S_LOAD;
        S_LOAD: begin
          v_q <= rdata_i;
          if (mode_q == wvbr_pkg::MODE_REPAIR) begin
            dq_q    <= PW'(excess_q) * PW'(rdata_i - min_i);
            rem_q   <= '0;
            bit_q   <= '0;
            state_q <= S_DIV;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_DIV: begin
          rem_q <= ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
          dq_q  <= {dq_q[PW-2:0], ge};
          bit_q <= bit_q + BW'(1);
          if (bit_q == BW'(PW - 1)) state_q <= S_EMIT;
        end
        S_EMIT: begin
          weight_o <= vfin;
          cash_o   <= fin ? $signed(cash_sat) : '0;
          status_o <= fin ? status : wvbr_pkg::STATUS_OK;
          last_o   <= fin;
          newsum_q <= total[SW-1:0];
          idx_q    <= idx_q + CW'(1);
          state_q  <= fin ? S_IDLE : S_READ;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign desc_ack_o = (state_q == S_IDLE) && desc_valid_i;
  assign raddr_o    = idx_q[AW-1:0];
  assign active_o   = (state_q != S_IDLE);
endmodule
`default_nettype wire

### design/weight_vector_budget_repair.sv
// ----------------------------------------------------------------------------
// weight_vector_budget_repair
// Clamps a vector of Q2.16 weights and repairs it to fit a budget of 1.0.
//
// Input: one weight per beat, taken when start_i is high and busy_o low;
// last_in_i closes the vector, as does the entry that fills MAX_ENTRIES.
// Non-closing beats are taken back to back.
// After a closing beat busy_o stays high while the vector is walked:
// each entry is read, loaded and emitted; when a repair is needed the
// bit-serial divider forms its share between the load and the emit.
// Each result beat shows on the result ports for one cycle with
// result_valid_o; cash_out_o and status_o are meaningful on the beat with
// last_out_o. The receiver cannot stall; beats are never held back.
// Config: cfg_index_i 0 = min weight, 1 = max weight, always ready; write
// only while idle. Reset clears config to 0 / 1.0 and empties the block;
// the entry store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module weight_vector_budget_repair #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic signed [wvbr_pkg::IN_W-1:0]      weight_in_i,
  input  wire logic                                  last_in_i,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic                                  cfg_index_i,
  input  wire logic [wvbr_pkg::W_W-1:0]              cfg_data_i,
  output logic                                       result_valid_o,
  output logic [wvbr_pkg::W_W-1:0]                   weight_out_o,
  output logic signed [wvbr_pkg::CASH_W-1:0]         cash_out_o,
  output logic [wvbr_pkg::ST_W-1:0]                  status_o,
  output logic                                       last_out_o
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic                     accept, desc_valid, desc_ack, back_active, we;
  wvbr_pkg::desc_t          desc;
  logic [CW-1:0]            desc_count;
  logic [wvbr_pkg::W_W-1:0] min_w, max_w, wdata, rdata;
  logic [AW-1:0]            waddr, raddr;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = desc_valid | back_active;
  assign accept      = start_i & ~busy_o;

  wvbr_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .accept_i(accept), .weight_i(weight_in_i), .last_i(last_in_i),
    .desc_ack_i(desc_ack), .desc_valid_o(desc_valid), .desc_o(desc),
    .desc_count_o(desc_count), .min_o(min_w), .max_o(max_w),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  wvbr_ram #(.WIDTH(wvbr_pkg::W_W), .DEPTH(MAX_ENTRIES)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  wvbr_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .desc_valid_i(desc_valid), .desc_i(desc), .desc_count_i(desc_count),
    .desc_ack_o(desc_ack), .min_i(min_w), .max_i(max_w),
    .raddr_o(raddr), .rdata_i(rdata), .active_o(back_active),
    .valid_o(result_valid_o), .weight_o(weight_out_o), .cash_o(cash_out_o),
    .status_o(status_o), .last_o(last_out_o)
  );
endmodule
`default_nettype wire

### design/wvbr_checker.sv
// ----------------------------------------------------------------------------
// wvbr_checker
// Port-level checks on result beats and busy after a closing beat.
// ----------------------------------------------------------------------------
`default_nettype none
module wvbr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        last_in_i,
  input wire logic        result_valid_o,
  input wire logic signed [17:0] cash_out_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_out_o
);
  a_mid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_out_o |-> cash_out_o == 0 &&
      status_o == wvbr_pkg::STATUS_OK)
    else $error("cash/status set on a non-last beat");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == wvbr_pkg::STATUS_OK ||
      status_o == wvbr_pkg::STATUS_STUCK || status_o == wvbr_pkg::STATUS_NEG))
    else $error("bad status code");

  a_neg_cash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == wvbr_pkg::STATUS_NEG |-> cash_out_o < 0)
    else $error("negative-cash status with non-negative cash");

  a_busy_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_in_i |=> busy_o)
    else $error("not busy after closing beat");
endmodule

bind weight_vector_budget_repair wvbr_checker u_wvbr_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .last_in_i,
  .result_valid_o, .cash_out_o, .status_o, .last_out_o
);
`default_nettype wire

### dv/tb_weight_vector_budget_repair.sv
// ----------------------------------------------------------------------------
// tb_weight_vector_budget_repair
// Self-checking bench: feeds weight vectors through the command port, models
// the clamp / budget repair in-bench and compares every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_weight_vector_budget_repair;

  localparam int MAX_N = 32;

  typedef struct packed {
    logic [wvbr_pkg::W_W-1:0]           weight;
    logic signed [wvbr_pkg::CASH_W-1:0] cash;
    logic [wvbr_pkg::ST_W-1:0]          status;
    logic                               last;
  } repair_beat_t;

  typedef struct {
    logic signed [wvbr_pkg::IN_W-1:0]   weight;
    logic                               last;
    logic                               chk;    // typed-in expectation present
    logic [wvbr_pkg::W_W-1:0]           exp_w;
    logic signed [wvbr_pkg::CASH_W-1:0] exp_cash;
    logic [wvbr_pkg::ST_W-1:0]          exp_st;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [wvbr_pkg::IN_W-1:0] weight_in_i = '0;
  logic last_in_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_index_i = wvbr_pkg::CFG_MIN;
  logic [wvbr_pkg::W_W-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, result_valid_o, last_out_o;
  logic [wvbr_pkg::W_W-1:0] weight_out_o;
  logic signed [wvbr_pkg::CASH_W-1:0] cash_out_o;
  logic [wvbr_pkg::ST_W-1:0] status_o;

  weight_vector_budget_repair #(.MAX_ENTRIES(MAX_N)) i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .weight_in_i, .last_in_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .weight_out_o, .cash_out_o, .status_o, .last_out_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  longint lo_wt = 0, hi_wt = 65536;
  longint held_w[MAX_N];
  int held_n = 0;
  repair_beat_t repaired_q[$];
  int mismatches = 0;
  int idle_pct = 0;

  function automatic longint clip(longint w);
    if (w > hi_wt) w = hi_wt;
    if (w < lo_wt) w = lo_wt;
    return w;
  endfunction

  // stores one entry; on a closing entry queues the repaired vector
  function automatic void predict_repair(logic signed [wvbr_pkg::IN_W-1:0] win, logic lst);
    longint s, hs, cash, ex, v, ns;
    logic [wvbr_pkg::ST_W-1:0] st;
    repair_beat_t b;
    st = wvbr_pkg::STATUS_OK;
    held_w[held_n] = clip(longint'(win));
    held_n++;
    if (!lst && held_n < MAX_N) return;
    s = 0; hs = 0;
    for (int i = 0; i < held_n; i++) begin
      s += held_w[i];
      hs += held_w[i] - lo_wt;
    end
    if (s <= 65536) cash = 65536 - s;
    else if (hs == 0) begin
      cash = 65536 - s;
      st = wvbr_pkg::STATUS_STUCK;
    end else begin
      ex = s - 65536;
      ns = 0;
      for (int i = 0; i < held_n; i++) begin
        v = held_w[i];
        v = clip(v - (ex * (v - lo_wt)) / hs);
        held_w[i] = v;
        ns += v;
      end
      cash = 65536 - ns;
      if (cash < 0) st = wvbr_pkg::STATUS_NEG;
    end
    if (cash < -131072) cash = -131072;
    for (int i = 0; i < held_n; i++) begin
      b.weight = held_w[i][wvbr_pkg::W_W-1:0];
      b.last = (i == held_n - 1);
      b.cash = b.last ? wvbr_pkg::CASH_W'(cash) : '0;
      b.status = b.last ? st : wvbr_pkg::STATUS_OK;
      repaired_q = {repaired_q, b};
    end
    held_n = 0;
  endfunction

  always @(posedge clk_i) begin
    repair_beat_t e;
    if (rst_ni && result_valid_o) begin
      if (repaired_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat w=%0d", weight_out_o);
      end else begin
        e = repaired_q.pop_front();
        if (e.weight !== weight_out_o || e.cash !== cash_out_o ||
            e.status !== status_o || e.last !== last_out_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w=%0d c=%0d s=%0d l=%0b got w=%0d c=%0d s=%0d l=%0b",
                     e.weight, e.cash, e.status, e.last,
                     weight_out_o, cash_out_o, status_o, last_out_o);
        end
      end
    end
  end

  // sender goes quiet until every expected beat has come
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (repaired_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [wvbr_pkg::W_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == wvbr_pkg::CFG_MIN) lo_wt = val; else hi_wt = val;
    @(posedge clk_i);
  endtask

  // one beat, with random idle before it
  task automatic send_weight(logic signed [wvbr_pkg::IN_W-1:0] w, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    weight_in_i <= w;
    last_in_i <= lst;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_repair(w, lst);
  endtask

  function automatic logic signed [wvbr_pkg::IN_W-1:0] rand_weight();
    case ($urandom_range(5))
      0: return wvbr_pkg::IN_W'($urandom);
      1: return wvbr_pkg::IN_W'($urandom_range(65536));
      2: return wvbr_pkg::IN_W'($urandom_range(20000));
      3: return $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
      default: return wvbr_pkg::IN_W'($urandom_range(40000));
    endcase
  endfunction

  vec_row_t dir_rows[$];

  initial begin
    vec_row_t r;
    int sent, vlen, v;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: {weight, last, chk, exp weight, exp cash, exp status}
    dir_rows = '{
      '{18'sd0, 1'b1, 1'b1, 17'd0, 18'sd65536, wvbr_pkg::STATUS_OK},
      '{18'sd65536, 1'b1, 1'b1, 17'd65536, 18'sd0, wvbr_pkg::STATUS_OK},
      '{18'sh1FFFF, 1'b1, 1'b1, 17'd65536, 18'sd0, wvbr_pkg::STATUS_OK},
      '{18'sh20000, 1'b1, 1'b1, 17'd0, 18'sd65536, wvbr_pkg::STATUS_OK},
      '{18'sd40000, 1'b0, 1'b0, 17'd0, 18'sd0, wvbr_pkg::STATUS_OK},
      '{18'sd40000, 1'b1, 1'b0, 17'd0, 18'sd0, wvbr_pkg::STATUS_OK},
      '{18'sd65536, 1'b0, 1'b0, 17'd0, 18'sd0, wvbr_pkg::STATUS_OK},
      '{18'sd65536, 1'b0, 1'b0, 17'd0, 18'sd0, wvbr_pkg::STATUS_OK},
      '{18'sd1, 1'b1, 1'b0, 17'd0, 18'sd0, wvbr_pkg::STATUS_OK},
      '{-18'sd5, 1'b0, 1'b0, 17'd0, 18'sd0, wvbr_pkg::STATUS_OK},
      '{18'sd30000, 1'b1, 1'b0, 17'd0, 18'sd0, wvbr_pkg::STATUS_OK}
    };
    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      send_weight(r.weight, r.last);
      if (r.chk) repaired_q[repaired_q.size()-1] =
        '{r.exp_w, r.exp_cash, r.exp_st, 1'b1};
    end
    // full store closes without last
    for (int i = 0; i < MAX_N; i++) send_weight(18'sd3000, 1'b0);
    drain();
    // min above max: all headrooms zero, cannot reduce
    write_reg(wvbr_pkg::CFG_MAX, 17'd10000);
    write_reg(wvbr_pkg::CFG_MIN, 17'd40000);
    send_weight(18'sd0, 1'b0);
    send_weight(18'sd0, 1'b1);
    drain();
    // every entry at max, large min: cash saturates
    write_reg(wvbr_pkg::CFG_MIN, 17'd65536);
    write_reg(wvbr_pkg::CFG_MAX, 17'd65536);
    for (int i = 0; i < 4; i++) send_weight(18'sd0, i == 3);
    drain();

    // random phases with varied settings and idling, about 52 beats each
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 20;
        default: idle_pct = 56;
      endcase
      case (ph)
        0: begin
          write_reg(wvbr_pkg::CFG_MIN, 17'd0);
          write_reg(wvbr_pkg::CFG_MAX, 17'd65536);
        end
        1: begin
          write_reg(wvbr_pkg::CFG_MIN, 17'd0);
          write_reg(wvbr_pkg::CFG_MAX, 17'd0);
        end
        7: begin
          write_reg(wvbr_pkg::CFG_MIN, 17'd50000);
          write_reg(wvbr_pkg::CFG_MAX, 17'd20000);
        end
        default: begin
          write_reg(wvbr_pkg::CFG_MIN, 17'($urandom_range(20000)));
          write_reg(wvbr_pkg::CFG_MAX, 17'($urandom_range(30000, 65536)));
        end
      endcase
      v = 0;
      while (sent < (ph + 1) * 52) begin
        vlen = ($urandom_range(9) == 0) ? $urandom_range(20, MAX_N) : $urandom_range(1, 6);
        for (int i = 0; i < vlen && i < MAX_N; i++) begin
          send_weight(rand_weight(), i == vlen - 1);
          sent++;
        end
        if (v == 5) drain();
        v++;
      end
      drain();
    end

    if (mismatches == 0 && repaired_q.size() == 0)
      $display("tb_weight_vector_budget_repair OK");
    else
      $display("tb_weight_vector_budget_repair NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_weight_vector_budget_repair NOT OK");
    $finish;
  end

endmodule
